// ===== src/gcrtn_pkg.sv =====
// ----------------------------------------------------------------------------
// gcrtn_pkg: shared types and tables of the gcr track nibblizer
// item structs, command struct, disk byte tables and interleave
// ----------------------------------------------------------------------------
package gcrtn_pkg;

  localparam int unsigned TRACK_BYTES   = 6384;
  localparam int unsigned GAP_ONE       = 48;
  localparam int unsigned SECTOR_BYTES  = 396;
  localparam int unsigned DATA_START    = 23;
  localparam int unsigned DATA_NIBBLES  = 343;
  localparam int unsigned AUX_GROUPS    = 86;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned CMD_DEPTH_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [11:0] byte_address;
    logic [7:0]  load_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] disk_byte;
    logic       track_end;
  } out_item_t;

  // classified pull command handed from front to back
  typedef enum logic [1:0] {
    K_CONST = 2'd0,   // fixed byte, given in value
    K_AUX   = 2'd1,   // auxiliary group, three reads
    K_HIGH  = 2'd2,   // high six bits, one read
    K_LAST  = 2'd3    // closing checksum nibble
  } kind_t;

  typedef struct packed {
    logic       load;       // buffer write: address in logical and k, data in value
    kind_t      kind;
    logic [7:0] value;      // constant byte
    logic       clear;      // reset chain (prologue end)
    logic [3:0] logical;
    logic [7:0] k;          // 0..255 offset within group
    logic       mask_top;   // last two aux groups
    logic       track_end;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE, B_RD_A, B_RD_B, B_RD_C, B_WAIT, B_EMIT
  } bstate_t;

  function automatic logic [7:0] gcr_map(input logic [5:0] v);
    logic [7:0] t [64];
    t = '{8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
          8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
          8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
          8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
          8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
          8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
          8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
          8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF};
    return t[v];
  endfunction

  function automatic logic [3:0] interleave(input logic mode, input logic [3:0] p);
    logic [3:0] pro [16];
    logic [3:0] dos [16];
    pro = '{4'h0, 4'h8, 4'h1, 4'h9, 4'h2, 4'hA, 4'h3, 4'hB,
            4'h4, 4'hC, 4'h5, 4'hD, 4'h6, 4'hE, 4'h7, 4'hF};
    dos = '{4'h0, 4'h7, 4'hE, 4'h6, 4'hD, 4'h5, 4'hC, 4'h4,
            4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'hF};
    return mode ? dos[p] : pro[p];
  endfunction

  function automatic logic [7:0] odd_half(input logic [7:0] x);
    return ((x >> 1) & 8'h55) | 8'hAA;
  endfunction

  function automatic logic [7:0] even_half(input logic [7:0] x);
    return (x & 8'h55) | 8'hAA;
  endfunction

  function automatic logic [1:0] swap_pair(input logic [7:0] x);
    return {x[0], x[1]};
  endfunction

endpackage

// ===== src/gcr_track_nibblizer_unit.sv =====
// ----------------------------------------------------------------------------
// gcr_track_nibblizer_unit: 6-and-2 gcr track stream encoder
// loads fill a 4096 byte track buffer, pulls return the encoded stream
// ----------------------------------------------------------------------------
// sequence: fixed bytes and the closing nibble go straight to the emit state,
// high-bit nibbles pass rd_c, wait and emit (one read), auxiliary nibbles
// rd_a, rd_b, rd_c, wait and emit (3 reads); the back end holds the next pull
// until the waiting byte is taken; a load is written while the back end is idle
// reset: synchronous active low; position, chain and registers cleared,
// order defaults to dos; buffer contents undefined until loaded
module gcr_track_nibblizer_unit import gcrtn_pkg::*; #(
  parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0] track_number_r;
  logic       order_mode_r;
  logic       acc, pull, load;
  cmd_t       fcmd, qcmd;
  logic       q_full, q_empty, q_take;
  logic       res_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_number_r <= '0;
      order_mode_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRACK: track_number_r <= cfg_data;
        CFG_ORDER: order_mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // loads and pulls share the queue, so the buffer sees them in order
  assign in_full = q_full;
  assign acc     = in_push && !in_full;
  assign pull    = acc && (in_item.opcode == OP_PULL);
  assign load    = acc && (in_item.opcode == OP_LOAD);

  gcrtn_front u_front (
    .clk, .rst_n, .pull, .load,
    .ld_addr      (in_item.byte_address),
    .ld_data      (in_item.load_data),
    .track_number (track_number_r),
    .order_mode   (order_mode_r),
    .cmd          (fcmd)
  );

  gcrtn_cmdq #(.DEPTH(CMD_DEPTH)) u_q (
    .clk, .rst_n,
    .wr (acc), .wdata (fcmd), .full (q_full),
    .rd (q_take), .rdata (qcmd), .empty (q_empty)
  );

  gcrtn_back u_back (
    .clk, .rst_n,
    .cmd_valid (!q_empty),
    .cmd       (qcmd),
    .cmd_take  (q_take),
    .res_valid (res_valid),
    .res       (out_item),
    .res_pop   (out_pop)
  );

  assign out_empty = !res_valid;

`ifndef SYNTHESIS
  // a queued pull is not taken while a result still waits
  a_no_take_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !out_pop |-> !(q_take && !qcmd.load))
    else $error("cmd taken over held item");
  // a result popped leaves the output empty the next cycle
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop |=> out_empty) else $error("result repeated");
  // pushes are refused only when the queue is full
  a_full_is_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_full) else $error("bad full");
`endif

endmodule

// ===== src/gcrtn_front.sv =====
// ----------------------------------------------------------------------------
// gcrtn_front: stream position tracker and pull classifier
// walks the track layout and turns each pull into a command
// ----------------------------------------------------------------------------
module gcrtn_front import gcrtn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pull,        // accepted pull item
  input  logic        load,        // accepted load item
  input  logic [11:0] ld_addr,
  input  logic [7:0]  ld_data,
  input  logic [7:0]  track_number,
  input  logic        order_mode,
  output cmd_t        cmd
);

  logic [12:0] pos_r, pos_nxt;
  logic        in_gap_r, in_gap_nxt;   // first sync gap
  logic [8:0]  off_r, off_nxt;         // offset within sector
  logic [3:0]  sec_r, sec_nxt;
  logic [8:0]  k;
  logic [3:0]  chk;
  logic        last_byte;

  assign last_byte = (pos_r == 13'(TRACK_BYTES - 1));
  assign k         = off_r - 9'(DATA_START);
  assign chk       = sec_r;

  always_comb begin
    logic [7:0] c;
    c   = 8'hFE ^ track_number ^ {4'h0, chk};
    cmd = '0;
    cmd.kind      = K_CONST;
    cmd.value     = 8'hFF;
    cmd.track_end = last_byte;
    cmd.logical   = interleave(order_mode, sec_r);
    if (!in_gap_r) begin
      unique case (off_r)
        9'd0, 9'd20:        cmd.value = 8'hD5;
        9'd1, 9'd12, 9'd21: cmd.value = 8'hAA;
        9'd2:  cmd.value = 8'h96;
        9'd3:  cmd.value = odd_half(8'hFE);
        9'd4:  cmd.value = even_half(8'hFE);
        9'd5:  cmd.value = odd_half(track_number);
        9'd6:  cmd.value = even_half(track_number);
        9'd7:  cmd.value = odd_half({4'h0, sec_r});
        9'd8:  cmd.value = even_half({4'h0, sec_r});
        9'd9:  cmd.value = odd_half(c);
        9'd10: cmd.value = even_half(c);
        9'd11: cmd.value = 8'hDE;
        9'd13: cmd.value = 8'hEB;
        9'd22: begin
          cmd.value = 8'hAD;
          cmd.clear = 1'b1;
        end
        9'd366: cmd.value = 8'hDE;
        9'd367: cmd.value = 8'hAA;
        9'd368: cmd.value = 8'hEB;
        default: begin
          if (off_r >= 9'(DATA_START) && off_r < 9'(DATA_START + DATA_NIBBLES)) begin
            if (k < 9'(AUX_GROUPS)) begin
              cmd.kind     = K_AUX;
              cmd.k        = k[7:0];
              cmd.mask_top = (k >= 9'(AUX_GROUPS - 2));
            end else if (k < 9'(DATA_NIBBLES - 1)) begin
              cmd.kind = K_HIGH;
              cmd.k    = 8'(k - 9'(AUX_GROUPS));
            end else begin
              cmd.kind = K_LAST;
            end
          end
        end
      endcase
    end
    // loads travel the same queue so the buffer sees items in order
    if (load) begin
      cmd.load    = 1'b1;
      cmd.logical = ld_addr[11:8];
      cmd.k       = ld_addr[7:0];
      cmd.value   = ld_data;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    in_gap_nxt = in_gap_r;
    off_nxt    = off_r;
    sec_nxt    = sec_r;
    if (pull) begin
      if (last_byte) begin
        pos_nxt    = '0;
        in_gap_nxt = 1'b1;
        off_nxt    = '0;
        sec_nxt    = '0;
      end else begin
        pos_nxt = pos_r + 13'd1;
        if (in_gap_r) begin
          if (pos_r == 13'(GAP_ONE - 1)) in_gap_nxt = 1'b0;
        end else if (off_r == 9'(SECTOR_BYTES - 1)) begin
          off_nxt = '0;
          sec_nxt = sec_r + 4'd1;
        end else begin
          off_nxt = off_r + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      in_gap_r <= 1'b1;
      off_r    <= '0;
      sec_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      in_gap_r <= in_gap_nxt;
      off_r    <= off_nxt;
      sec_r    <= sec_nxt;
    end
  end

endmodule

// ===== src/gcrtn_cmdq.sv =====
// ----------------------------------------------------------------------------
// gcrtn_cmdq: short command queue between front and back
// register based fifo with count
// ----------------------------------------------------------------------------
module gcrtn_cmdq import gcrtn_pkg::*; #(
  parameter int unsigned DEPTH = CMD_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wdata,
  output logic full,
  input  logic rd,
  output cmd_t rdata,
  output logic empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t           mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr && !full) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd && !empty) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

// ===== src/gcrtn_back.sv =====
// ----------------------------------------------------------------------------
// gcrtn_back: command executor with track buffer and chain register
// loads write the buffer; pulls read it and emit the disk byte
// ----------------------------------------------------------------------------
module gcrtn_back import gcrtn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  output logic       res_valid,
  output out_item_t  res,
  input  logic       res_pop
);

  logic [7:0]  store [4096];
  logic [7:0]  rd_data_r;
  logic [11:0] rd_addr;
  logic        rd_en;
  logic        ld_take;

  bstate_t    st_r, st_nxt;
  cmd_t       cur_r;
  logic [1:0] pa_r, pb_r;
  logic [5:0] chain_r;
  logic [5:0] curv;
  out_item_t  res_r;
  logic       res_valid_r;

  // a queued load is written while the sequencer is idle
  assign ld_take = (st_r == B_IDLE) && cmd_valid && cmd.load;

  // buffer: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (ld_take) store[{cmd.logical, cmd.k}] <= cmd.value;
    else if (rd_en) rd_data_r <= store[rd_addr];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (cmd_valid && !cmd.load && !res_valid_r) begin
        priority case (cmd.kind)
          K_AUX:  st_nxt = B_RD_A;
          K_HIGH: st_nxt = B_RD_C;
          default: st_nxt = B_EMIT;
        endcase
      end
      B_RD_A: st_nxt = B_RD_B;
      B_RD_B: st_nxt = B_RD_C;
      B_RD_C: st_nxt = B_WAIT;
      B_WAIT: st_nxt = B_EMIT;
      B_EMIT: st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // read address per step; the result of each step arrives in the next cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {cur_r.logical, cur_r.k};
    unique case (st_r)
      B_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = {cur_r.logical, 8'(cur_r.k + 8'hAC)};
      end
      B_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = {cur_r.logical, 8'(cur_r.k + 8'h56)};
      end
      B_RD_C: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    unique case (cur_r.kind)
      K_AUX:  curv = cur_r.mask_top ? {2'b00, pb_r, swap_pair(rd_data_r)}
                                    : {pa_r, pb_r, swap_pair(rd_data_r)};
      K_HIGH: curv = rd_data_r[7:2];
      default: curv = '0;
    endcase
  end

  assign cmd_take  = (st_r == B_IDLE) && cmd_valid && (cmd.load || !res_valid_r);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cur_r <= '0;
    else if (cmd_take && !cmd.load) cur_r <= cmd;
  end

  always_ff @(posedge clk) begin
    if (st_r == B_RD_B) pa_r <= swap_pair(rd_data_r);
    if (st_r == B_RD_C && cur_r.kind == K_AUX) pb_r <= swap_pair(rd_data_r);
    if (st_r == B_EMIT) begin
      res_r.track_end <= cur_r.track_end;
      res_r.disk_byte <= (cur_r.kind == K_CONST) ? cur_r.value : gcr_map(chain_r ^ curv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      chain_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_EMIT) begin
        res_valid_r <= 1'b1;
        if (cur_r.kind == K_CONST) begin
          if (cur_r.clear) chain_r <= '0;
        end else begin
          chain_r <= curv;
        end
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the gcr track nibblizer unit
// loads the two logical sectors that the pulls reach, then pulls the first
// two physical sectors under several track and interleave settings with
// loads mixed in; every disk byte is checked against a predictor kept
// inside this module
// ----------------------------------------------------------------------------
module tb_top;
  import gcrtn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;   // cycles with nothing accepted, popped or configured
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_item_t              in_item;
  logic                  out_empty;
  logic                  out_pop;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gcr_track_nibblizer_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // disk byte table and sector interleave, own copies
  logic [7:0] nib_code [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF};
  logic [3:0] skew_map [2][16] = '{
    '{4'h0, 4'h8, 4'h1, 4'h9, 4'h2, 4'hA, 4'h3, 4'hB,
      4'h4, 4'hC, 4'h5, 4'hD, 4'h6, 4'hE, 4'h7, 4'hF},
    '{4'h0, 4'h7, 4'hE, 4'h6, 4'hD, 4'h5, 4'hC, 4'h4,
      4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'hF}};

  // predictor state
  logic [7:0]  shadow_track [4096];
  logic [12:0] disk_pos;
  logic [5:0]  chain_prev;
  logic [7:0]  trk_reg;
  logic        order_reg;

  in_item_t  pending_items [$];
  out_item_t disk_bytes_due [$];
  int        mismatches;
  int        idle_cycles;
  bit        in_taken;
  bit        calm;          // no idling in the last part
  bit        held_once;
  int        hold_cnt, in_gap, out_gap;

  function automatic logic [1:0] pair_swap(input logic [7:0] x);
    return {x[0], x[1]};
  endfunction

  function automatic logic [7:0] four_odd(input logic [7:0] x);
    return ((x >> 1) & 8'h55) | 8'hAA;
  endfunction

  function automatic logic [7:0] four_even(input logic [7:0] x);
    return (x & 8'h55) | 8'hAA;
  endfunction

  // 6-bit value k of a logical sector before chaining
  function automatic logic [5:0] sector_six(input logic [3:0] lsec, input int k);
    logic [11:0] base;
    logic [5:0]  v;
    base = {lsec, 8'h00};
    if (k < 86) begin
      v = {pair_swap(shadow_track[base + ((8'hAC + k) & 8'hFF)]),
           pair_swap(shadow_track[base + ((8'h56 + k) & 8'hFF)]),
           pair_swap(shadow_track[base + (k & 8'hFF)])};
      // last two auxiliary groups keep only the lower two pairs
      if (k >= 84) v = v & 6'h0F;
      return v;
    end
    return 6'(shadow_track[base + ((k - 86) & 8'hFF)] >> 2);
  endfunction

  // next disk byte of the track stream, advances position and chain
  function automatic out_item_t next_disk_byte();
    out_item_t  r;
    int         rel, phys, off, k;
    logic [7:0] sec, chk, b;
    logic [5:0] cur;
    b = 8'hFF;
    if (disk_pos >= 48) begin
      rel  = disk_pos - 48;
      phys = rel / 396;
      off  = rel % 396;
      sec  = {4'h0, phys[3:0]};
      chk  = 8'hFE ^ trk_reg ^ sec;
      case (off)
        0, 20:     b = 8'hD5;
        1, 12, 21: b = 8'hAA;
        2:         b = 8'h96;
        3:         b = four_odd(8'hFE);
        4:         b = four_even(8'hFE);
        5:         b = four_odd(trk_reg);
        6:         b = four_even(trk_reg);
        7:         b = four_odd(sec);
        8:         b = four_even(sec);
        9:         b = four_odd(chk);
        10:        b = four_even(chk);
        11:        b = 8'hDE;
        13:        b = 8'hEB;
        22: begin
          chain_prev = '0;
          b = 8'hAD;
        end
        366:       b = 8'hDE;
        367:       b = 8'hAA;
        368:       b = 8'hEB;
        default: begin
          if (off >= 23 && off < 366) begin
            k = off - 23;
            // closing checksum nibble chains against zero
            cur = (k < 342) ? sector_six(skew_map[order_reg][sec[3:0]], k) : 6'h00;
            b = nib_code[chain_prev ^ cur];
            chain_prev = cur;
          end
        end
      endcase
    end
    r.disk_byte = b;
    r.track_end = (disk_pos == 6383);
    disk_pos = (disk_pos == 6383) ? 13'd0 : disk_pos + 13'd1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accept side, result check and watchdog, all at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    bit        moved;
    moved    = 1'b0;
    in_taken = 1'b0;
    if (rst_n && in_push && !in_full) begin
      in_taken = 1'b1;
      moved    = 1'b1;
      if (in_item.opcode == OP_LOAD)
        shadow_track[in_item.byte_address] = in_item.load_data;
      else
        disk_bytes_due.push_back(next_disk_byte());
    end
    if (rst_n && out_pop && !out_empty) begin
      moved = 1'b1;
      if (disk_bytes_due.size() == 0) begin
        report_mismatch("unexpected item", out_item.disk_byte, 8'h00);
      end else begin
        want = disk_bytes_due.pop_front();
        if (out_item.disk_byte !== want.disk_byte)
          report_mismatch("disk_byte", out_item.disk_byte, want.disk_byte);
        if (out_item.track_end !== want.track_end)
          report_mismatch("track_end", {7'd0, out_item.track_end}, {7'd0, want.track_end});
      end
    end
    if (cfg_we) moved = 1'b1;
    idle_cycles = (moved || !rst_n) ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // driver: next item at the falling edge, random gap bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && !in_taken) begin
      // item still waiting for acceptance
    end else if (in_gap > 0) begin
      in_gap--;
      in_push <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      in_gap = $urandom_range(0, 10);
      in_push <= 1'b0;
    end else if (pending_items.size() > 0) begin
      in_item <= pending_items.pop_front();
      in_push <= 1'b1;
    end else begin
      in_push <= 1'b0;
    end
  end

  // receiver: random stall bursts and one long hold-off to fill the block
  always @(negedge clk) begin
    if (!held_once && disk_bytes_due.size() > 0) begin
      held_once = 1'b1;
      hold_cnt  = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_pop <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      out_gap = $urandom_range(0, 10);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  function automatic in_item_t mk_load(input logic [11:0] a, input logic [7:0] d);
    in_item_t it;
    it.opcode       = OP_LOAD;
    it.byte_address = a;
    it.load_data    = d;
    return it;
  endfunction

  function automatic in_item_t mk_pull();
    in_item_t it;
    it.opcode       = OP_PULL;
    it.byte_address = 12'($urandom_range(0, 4095));
    it.load_data    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // wait until every item is in and every disk byte is out, then settle
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || in_push || disk_bytes_due.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_TRACK) trk_reg = val;
    else order_reg = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // pulls mixed with a share of random loads into the sectors in use
  task automatic queue_pulls(input int n, input int load_pct);
    logic [3:0] lsec;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < load_pct) begin
        lsec = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'h8;
        pending_items.push_back(mk_load({lsec, 8'($urandom_range(0, 255))},
                                        8'($urandom_range(0, 255))));
      end
      pending_items.push_back(mk_pull());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_item   = '0;
    out_pop   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_TRACK;
    cfg_data  = '0;
    disk_pos  = '0;
    chain_prev = '0;
    trk_reg   = 8'h00;
    order_reg = 1'b1;
    mismatches = 0;
    idle_cycles = 0;
    calm = 1'b0;
    held_once = 1'b0;
    hold_cnt = 0;
    in_gap = 0;
    out_gap = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // logical sector 0 (physical 0 in both orders) and 8 (physical 1 in
    // prodos order) loaded first, so no pull reads an unwritten byte;
    // sector 8 gets all-ones then all-zero content for the extremes
    for (int a = 0; a < 256; a++) begin
      pending_items.push_back(mk_load(12'(a), 8'($urandom_range(0, 255))));
      pending_items.push_back(mk_load(12'(12'h800 + a), (a < 128) ? 8'hFF : 8'h00));
    end
    pending_items.push_back(mk_load(12'h000, 8'hFF));
    pending_items.push_back(mk_load(12'h0FF, 8'h00));
    drain();

    // dos order, highest track number: gap, header and first data part
    write_reg(CFG_TRACK, 8'hFF);
    write_reg(CFG_ORDER, 8'h01);
    queue_pulls(300, 5);
    drain();

    // prodos order, track zero: rest of the first sector
    write_reg(CFG_TRACK, 8'h00);
    write_reg(CFG_ORDER, 8'h00);
    queue_pulls(144, 5);
    drain();

    // random track, prodos order, whole second sector, no idling
    calm = 1'b1;
    write_reg(CFG_TRACK, 8'($urandom_range(1, 254)));
    write_reg(CFG_ORDER, 8'h00);
    queue_pulls(396, 5);
    drain();

    if (mismatches == 0 && disk_bytes_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
